/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked every clock edge outside reset
`define MFHP_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked every clock edge, reset included
`define MFHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MFHP_ASSERT_RST(lbl, clk, rst, prop, msg)

`define MFHP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/mfhp_pkg.sv */
`default_nettype none

package mfhp_pkg;

   // header layout, byte offsets from the start of the frame
   localparam int HEADER_BYTES = 21;
   localparam int POS_TYPE     = 4;
   localparam int POS_TRACK    = 5;
   localparam int POS_FLAGS    = 6;
   localparam int POS_LENGTH   = 7;
   localparam int POS_SEQ      = 9;
   localparam int POS_STAMP    = 13;
   localparam int MAGIC_BYTES  = 4;

   localparam int COUNT_W = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int MFHP_QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [31:0] MAGIC_WORD_RST      = 32'h0000_0000;
   localparam logic [15:0] MAX_PAYLOAD_RST     = 16'hFFFF;
   localparam logic [7:0]  MAX_TRACK_RST       = 8'hFF;
   localparam logic [63:0] KNOWN_TYPE_MASK_RST = 64'd510;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAGIC_WORD      = 3'd0,
      REG_MAX_PAYLOAD     = 3'd1,
      REG_MAX_TRACK       = 3'd2,
      REG_KNOWN_TYPE_MASK = 3'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_LENGTH = 3'd1,
      ST_BAD_MAGIC  = 3'd2,
      ST_TOO_LARGE  = 3'd3,
      ST_BAD_TRACK  = 3'd4,
      ST_BAD_TYPE   = 3'd5
   } status_type;

   typedef struct packed {
      logic [31:0] magic_word;
      logic [15:0] max_payload;
      logic [7:0]  max_track;
      logic [63:0] known_type_mask;
   } cfg_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [7:0]  message_type;
      logic [7:0]  track_slot;
      logic [7:0]  flag_bits;
      logic [15:0] payload_length;
      logic [31:0] sequence_number;
      logic [63:0] timestamp_value;
      status_type  status;
      logic        last_item;
   } rsp_item_type;

   // which words the parser hands to the queue this cycle
   typedef struct packed {
      logic pay_valid;
      logic sum_valid;
   } push_type;

endpackage

`default_nettype wire

/* rtl/mfhp_if.sv */
`default_nettype none

interface mfhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mfhp_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  payload_byte;
   logic [7:0]  message_type;
   logic [7:0]  track_slot;
   logic [7:0]  flag_bits;
   logic [15:0] payload_length;
   logic [31:0] sequence_number;
   logic [63:0] timestamp_value;
   logic [2:0]  status;
   logic        last_item;

   modport source (output valid, output item_kind, output payload_byte,
      output message_type, output track_slot, output flag_bits,
      output payload_length, output sequence_number, output timestamp_value,
      output status, output last_item, input ready);
   modport sink (input valid, input item_kind, input payload_byte,
      input message_type, input track_slot, input flag_bits,
      input payload_length, input sequence_number, input timestamp_value,
      input status, input last_item, output ready);
endinterface

`default_nettype wire

/* rtl/mfhp_parse.sv */
`default_nettype none

module mfhp_parse import mfhp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         accept,
   input  logic [7:0]   data_byte,
   input  logic         last_byte,
   output push_type     push,
   output rsp_item_type pay_item,
   output rsp_item_type sum_item
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               magic_ok_ff, magic_ok_in;
   logic [7:0]         type_ff, type_in;
   logic [7:0]         track_ff, track_in;
   logic [7:0]         flags_ff, flags_in;
   logic [15:0]        length_ff, length_in;
   logic [31:0]        seq_ff, seq_in;
   logic [63:0]        stamp_ff, stamp_in;

   logic [7:0]         magic_byte;
   logic [1:0]         magic_pos;
   logic [COUNT_W-1:0] count_next;
   logic [COUNT_W-1:0] frame_size;
   status_type         frame_status;

   // first wire byte sits in the top bits
   assign magic_pos  = count_ff[1:0];
   assign magic_byte = 8'(cfg.magic_word >> (8 * (MAGIC_BYTES - 1 - int'(magic_pos))));

   // frame state after this byte, before any end-of-frame clear
   always_comb begin
      magic_ok_in = magic_ok_ff;
      type_in     = type_ff;
      track_in    = track_ff;
      flags_in    = flags_ff;
      length_in   = length_ff;
      seq_in      = seq_ff;
      stamp_in    = stamp_ff;
      pay_item    = '0;
      push.pay_valid = 1'b0;
      push.sum_valid = accept && last_byte;
      if (count_ff < COUNT_W'(POS_TYPE)) begin
         if (data_byte != magic_byte) begin
            magic_ok_in = 1'b0;
         end
      end else if (count_ff == COUNT_W'(POS_TYPE)) begin
         type_in = data_byte;
      end else if (count_ff == COUNT_W'(POS_TRACK)) begin
         track_in = data_byte;
      end else if (count_ff == COUNT_W'(POS_FLAGS)) begin
         flags_in = data_byte;
      end else if (count_ff < COUNT_W'(POS_SEQ)) begin
         length_in = {length_ff[7:0], data_byte};
      end else if (count_ff < COUNT_W'(POS_STAMP)) begin
         seq_in = {seq_ff[23:0], data_byte};
      end else if (count_ff < COUNT_W'(HEADER_BYTES)) begin
         stamp_in = {stamp_ff[55:0], data_byte};
      end else begin
         push.pay_valid        = accept;
         pay_item.item_kind    = KIND_PAYLOAD;
         pay_item.payload_byte = data_byte;
         pay_item.status       = ST_OK;
      end
      count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   end

   // checks in priority order
   assign frame_size = COUNT_W'(HEADER_BYTES) + COUNT_W'(length_in);

   always_comb begin
      if (count_next < COUNT_W'(HEADER_BYTES)) begin
         frame_status = ST_BAD_LENGTH;
      end else if (!magic_ok_in) begin
         frame_status = ST_BAD_MAGIC;
      end else if (length_in > cfg.max_payload) begin
         frame_status = ST_TOO_LARGE;
      end else if (frame_size != count_next) begin
         frame_status = ST_BAD_LENGTH;
      end else if (track_in > cfg.max_track) begin
         frame_status = ST_BAD_TRACK;
      end else if (type_in[7:6] != 2'b00 || !cfg.known_type_mask[type_in[5:0]]) begin
         frame_status = ST_BAD_TYPE;
      end else begin
         frame_status = ST_OK;
      end
   end

   always_comb begin
      sum_item.item_kind       = KIND_SUMMARY;
      sum_item.payload_byte    = '0;
      sum_item.message_type    = type_in;
      sum_item.track_slot      = track_in;
      sum_item.flag_bits       = flags_in;
      sum_item.payload_length  = length_in;
      sum_item.sequence_number = seq_in;
      sum_item.timestamp_value = stamp_in;
      sum_item.status          = frame_status;
      sum_item.last_item       = 1'b1;
   end

   assign count_in = (accept && last_byte) ? '0 : count_next;

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         count_ff    <= '0;
         magic_ok_ff <= 1'b1;
         type_ff     <= '0;
         track_ff    <= '0;
         flags_ff    <= '0;
         length_ff   <= '0;
         seq_ff      <= '0;
         stamp_ff    <= '0;
      end else if (accept) begin
         count_ff    <= count_in;
         magic_ok_ff <= magic_ok_in;
         type_ff     <= type_in;
         track_ff    <= track_in;
         flags_ff    <= flags_in;
         length_ff   <= length_in;
         seq_ff      <= seq_in;
         stamp_ff    <= stamp_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/mfhp_outq.sv */
`default_nettype none

module mfhp_outq import mfhp_pkg::*; #(
   parameter int DEPTH = MFHP_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  rsp_item_type pay_item,
   input  rsp_item_type sum_item,
   input  logic         pop,
   output rsp_item_type head,
   output logic         not_empty,
   output logic         has_room
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type       q_ff [DEPTH];
   rsp_item_type       q_in [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   base;
   logic [CNT_W-1:0]   npush;
   logic               pop_en;
   rsp_item_type       first;

   assign pop_en = pop && (count_ff != '0);
   assign base   = count_ff - CNT_W'(pop_en);
   assign npush  = CNT_W'(push.pay_valid) + CNT_W'(push.sum_valid);
   // a payload word always goes ahead of the summary of the same byte
   assign first  = push.pay_valid ? pay_item : sum_item;

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      rsp_item_type shifted;
      if (i < DEPTH - 1) begin : g_mid
         assign shifted = pop_en ? q_ff[i+1] : q_ff[i];
      end else begin : g_top
         assign shifted = q_ff[i];
      end
      always_comb begin
         q_in[i] = shifted;
         if (CNT_W'(i) == base && npush != '0) begin
            q_in[i] = first;
         end else if (CNT_W'(i) == base + 1'b1 && npush == CNT_W'(2)) begin
            q_in[i] = sum_item;
         end
      end
   end

   assign count_in = base + npush;

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head      = q_ff[0];
   assign not_empty = (count_ff != '0);
   // room for the two words the next byte may bring
   assign has_room  = (count_ff <= CNT_W'(DEPTH - 2));

endmodule

`default_nettype wire

/* rtl/media_frame_header_parser.sv */
// Media frame header parser. Frames enter one byte per word on req_chan,
// last_byte marking the final byte. The first 21 bytes are the header
// (magic, type, track, flags, 16-bit length, 32-bit sequence, 64-bit
// timestamp, all big-endian); later bytes leave on rsp_chan as payload
// words, and the final byte adds a summary word with the header and a
// status. A byte is taken every cycle while the output queue of
// QUEUE_DEPTH words (at least 3) holds no more than QUEUE_DEPTH-2 words;
// its words are registered there, draining one per cycle while rsp_chan
// is ready, sustaining one byte per cycle, plus a summary word when the
// last byte is payload. Configuration goes through csr_write_en, csr_index
// and csr_write_data; the user writes it only while the block is idle,
// which the block does not enforce. No startup pass after reset.
`default_nettype none

`include "assert_macros.svh"

module media_frame_header_parser import mfhp_pkg::*; #(
   parameter int QUEUE_DEPTH = MFHP_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   mfhp_req_if.sink               req_chan,
   mfhp_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   push_type     push;
   rsp_item_type pay_item;
   rsp_item_type sum_item;
   rsp_item_type head;
   logic         accept;
   logic         not_empty;
   logic         has_room;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_MAGIC_WORD:      cfg_in.magic_word      = csr_write_data[31:0];
            REG_MAX_PAYLOAD:     cfg_in.max_payload     = csr_write_data[15:0];
            REG_MAX_TRACK:       cfg_in.max_track       = csr_write_data[7:0];
            REG_KNOWN_TYPE_MASK: cfg_in.known_type_mask = csr_write_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word      <= MAGIC_WORD_RST;
         cfg_ff.max_payload     <= MAX_PAYLOAD_RST;
         cfg_ff.max_track       <= MAX_TRACK_RST;
         cfg_ff.known_type_mask <= KNOWN_TYPE_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_chan.ready = has_room;
   assign accept         = req_chan.valid && has_room;

   mfhp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .last_byte (req_chan.last_byte),
      .push      (push),
      .pay_item  (pay_item),
      .sum_item  (sum_item)
   );

   mfhp_outq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pay_item  (pay_item),
      .sum_item  (sum_item),
      .pop       (rsp_chan.valid && rsp_chan.ready),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   assign rsp_chan.valid           = not_empty;
   assign rsp_chan.item_kind       = head.item_kind;
   assign rsp_chan.payload_byte    = head.payload_byte;
   assign rsp_chan.message_type    = head.message_type;
   assign rsp_chan.track_slot      = head.track_slot;
   assign rsp_chan.flag_bits       = head.flag_bits;
   assign rsp_chan.payload_length  = head.payload_length;
   assign rsp_chan.sequence_number = head.sequence_number;
   assign rsp_chan.timestamp_value = head.timestamp_value;
   assign rsp_chan.status          = head.status;
   assign rsp_chan.last_item       = head.last_item;

   `MFHP_ASSERT_RST(a_last_gives_word, clock, reset, (accept && req_chan.last_byte) |=> rsp_chan.valid, "frame end left no word")
   `MFHP_ASSERT_RST(a_kind_matches_last, clock, reset, rsp_chan.valid |-> (rsp_chan.item_kind == rsp_chan.last_item), "summary mark and kind differ")
   `MFHP_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_chan.valid, "output valid right after reset")

endmodule

`default_nettype wire
